### rtl/set_assoc_lru_writeback_cache_tags_unit_macros.svh
// Assertion macros for the cache tag unit.
// Used by the top level; expects clk and rst in the including scope.
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_UNIT_MACROS_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_UNIT_MACROS_SVH

// Same-cycle implication.
`define SALC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache tag unit check failed");

// Next-cycle implication.
`define SALC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache tag unit check failed");

`endif

### rtl/salc_pkg.sv
// Shared types and constants for the cache tag unit.
// No dependencies; imported by every module but salc_ram.
package salc_pkg;

  localparam int TAG_W      = 32;
  localparam int RANK_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic [4:0] OFFSET_BITS_RST = 5'd5;
  localparam logic [3:0] SET_BITS_RST    = 4'd4;
  localparam logic [3:0] WAYS_IN_USE_RST = 4'd4;

  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] addr;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic       writeback;
    logic [2:0] way_used;
  } out_item_t;

  // one way of one set as kept in the tag RAM
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              valid;
    logic              dirty;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef enum logic {
    ALU_SCAN,
    ALU_UPDATE
  } alu_mode_t;

  typedef struct packed {
    logic in_ready;
    logic clearing;
    logic eval;
    logic upd_we;
    logic finish;
  } ctrl_flags_t;

  typedef struct packed {
    alu_mode_t         mode;
    logic              cmd;
    logic              found;
    logic              fill_inv;
    logic [RANK_W-1:0] ref_rank;
  } alu_ctl_t;

  typedef struct packed {
    logic match;
    logic invalid;
    logic greater;
  } alu_stat_t;

endpackage

### rtl/salc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/salc_way_alu.sv
// Shared per-way unit: tag compare, rank compare and line update.
// Depends on salc_pkg.
module salc_way_alu
  import salc_pkg::*;
#(
  parameter int WAY_W = 3
) (
  input  alu_ctl_t          ctl,
  input  line_t             cur,
  input  logic [TAG_W-1:0]  tag,
  input  logic [RANK_W-1:0] oldest,
  input  logic [WAY_W-1:0]  way,
  input  logic [WAY_W-1:0]  sel_way,
  output alu_stat_t         stat,
  output line_t             nxt
);

  logic [RANK_W-1:0] cmp_a;
  logic [RANK_W-1:0] cmp_b;
  logic              greater;
  logic              is_wr;

  // scan: is this way older than the oldest so far
  // update: is this way younger than the reference way
  always_comb begin
    if (ctl.mode == ALU_SCAN) begin
      cmp_a = cur.rank;
      cmp_b = oldest;
    end else begin
      cmp_a = ctl.ref_rank;
      cmp_b = cur.rank;
    end
  end

  assign greater      = cmp_a > cmp_b;
  assign is_wr        = ctl.cmd == CMD_WRITE;
  assign stat.match   = cur.valid && (cur.tag == tag);
  assign stat.invalid = !cur.valid;
  assign stat.greater = greater;

  always_comb begin
    nxt = cur;
    if (way == sel_way) begin
      nxt.tag   = tag;
      nxt.valid = 1'b1;
      nxt.dirty = ctl.found ? (cur.dirty | is_wr) : is_wr;
      nxt.rank  = '0;
    end else if (cur.valid && (ctl.fill_inv || greater) && cur.rank != RANK_MAX) begin
      nxt.rank = cur.rank + 1'b1;
    end
  end

endmodule

### rtl/salc_ctrl.sv
// Sequencer for the cache tag unit: clear sweep, way scan, update pass.
// Depends on salc_pkg.
module salc_ctrl
  import salc_pkg::*;
#(
  parameter int WAY_W  = 3,
  parameter int CNT_W  = 4,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [CNT_W-1:0]  nw,
  input  logic              out_free,
  output state_t            state,
  output ctrl_flags_t       flags,
  output logic [WAY_W-1:0]  idx,
  output logic [WAY_W-1:0]  eval_way,
  output logic [ADDR_W-1:0] clr_addr
);

  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             eval_vld;
  logic             rd_en;
  logic             last_eval;
  logic             last_upd;

  assign idx       = cnt[WAY_W-1:0];
  assign rd_en     = (state == ST_SCAN) && (cnt < nw);
  assign last_eval = eval_vld && (eval_way == WAY_W'(nw - 1'b1));
  assign last_upd  = cnt == (nw - 1'b1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (&clr_addr) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_eval) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (last_upd && out_free) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    flags.in_ready = state == ST_IDLE;
    flags.clearing = state == ST_CLEAR;
    flags.eval     = eval_vld;
    flags.upd_we   = state == ST_UPDATE;
    flags.finish   = (state == ST_UPDATE) && last_upd && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      eval_vld <= 1'b0;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      eval_vld <= rd_en;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_IDLE || last_eval) begin
        cnt <= '0;
      end else if (rd_en || (state == ST_UPDATE && !last_upd)) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // read data comes back in the cycle after the address
  always_ff @(posedge clk) begin
    eval_way <= idx;
  end

endmodule

### rtl/set_assoc_lru_writeback_cache_tags_unit.sv
// Set-associative write-back, write-allocate cache tag unit with LRU ranks.
// Depends on salc_pkg, salc_ram, salc_way_alu, salc_ctrl and the macros header.
//
// One item is a read or write access; each gives one result (hit, writeback,
// way_used). All lines of a set sit in one tag RAM, one entry per way, and a
// single compare/update unit walks them: it reads and checks the N ways in
// use, then writes back the new tags, dirty bits and ranks; the last write
// waits until the output register is free. A new item is taken only once the
// last one is through. After reset the RAM is cleared one entry per cycle,
// all 2^ceil(log2(MAX_SETS)) * 2^ceil(log2(MAX_WAYS)) entries (2048 with the
// defaults), before the first item is taken; configuration writes are taken
// at any time but only while no access is in flight are they safe.
`include "set_assoc_lru_writeback_cache_tags_unit_macros.svh"

module set_assoc_lru_writeback_cache_tags_unit
  import salc_pkg::*;
#(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int ADDR_W = SET_W + WAY_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int LINE_W = $bits(line_t);

  // configuration
  logic [4:0] offset_bits;
  logic [3:0] set_bits;
  logic [3:0] ways_in_use;

  logic [3:0]       sb_live;
  logic [CNT_W-1:0] nw;
  logic [5:0]       tag_shift;
  logic [31:0]      addr_shr;
  logic [SET_W-1:0] set_in;
  logic [TAG_W-1:0] tag_in;

  // current item
  logic             cmd_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;

  // scan results
  logic              found;
  logic [WAY_W-1:0]  hit_way;
  logic [RANK_W-1:0] hit_rank;
  logic              inv_found;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  vic_way;
  logic [RANK_W-1:0] oldest;
  logic              vic_dirty;
  line_t             row_copy [MAX_WAYS];

  state_t            state;
  ctrl_flags_t       flags;
  logic [WAY_W-1:0]  idx;
  logic [WAY_W-1:0]  eval_way;
  logic [ADDR_W-1:0] clr_addr;
  logic              out_free;
  logic              accept;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [LINE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [LINE_W-1:0] ram_rdata;
  line_t             rd_line;

  alu_ctl_t          alu_ctl;
  alu_stat_t         alu_stat;
  line_t             alu_cur;
  line_t             alu_nxt;
  logic [WAY_W-1:0]  sel_way;
  logic [WAY_W+2:0]  sel_way_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      set_bits    <= SET_BITS_RST;
      ways_in_use <= WAYS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS: offset_bits <= cfg_data;
        CFG_SET_BITS:    set_bits    <= cfg_data[3:0];
        CFG_WAYS_IN_USE: ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // geometry clamped to what the storage holds
  always_comb begin
    sb_live = (set_bits > 4'(SB_MAX)) ? 4'(SB_MAX) : set_bits;
    if (ways_in_use == 4'd0) begin
      nw = CNT_W'(1);
    end else if ({1'b0, ways_in_use} > 5'(MAX_WAYS)) begin
      nw = CNT_W'(MAX_WAYS);
    end else begin
      nw = CNT_W'(ways_in_use);
    end
  end

  assign tag_shift = {1'b0, offset_bits} + {2'b00, sb_live};
  assign addr_shr  = in_data.addr >> offset_bits;
  assign set_in    = addr_shr[SET_W-1:0] & ~({SET_W{1'b1}} << sb_live);
  assign tag_in    = TAG_W'({32'b0, in_data.addr} >> tag_shift);

  assign accept   = in_valid && flags.in_ready;
  assign in_ready = flags.in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= in_data.cmd;
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  salc_ctrl #(
    .WAY_W  (WAY_W),
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .nw       (nw),
    .out_free (out_free),
    .state    (state),
    .flags    (flags),
    .idx      (idx),
    .eval_way (eval_way),
    .clr_addr (clr_addr)
  );

  assign ram_we    = flags.clearing || flags.upd_we;
  assign ram_waddr = flags.clearing ? clr_addr : {set_q, idx};
  assign ram_wdata = flags.clearing ? '0 : alu_nxt;
  assign ram_raddr = {set_q, idx};
  assign rd_line   = line_t'(ram_rdata);

  salc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // hit way first, else first free way, else LRU victim
  always_comb begin
    if (found) begin
      sel_way = hit_way;
    end else if (inv_found) begin
      sel_way = inv_way;
    end else begin
      sel_way = vic_way;
    end
  end

  always_comb begin
    alu_ctl.mode     = (state == ST_UPDATE) ? ALU_UPDATE : ALU_SCAN;
    alu_ctl.cmd      = cmd_q;
    alu_ctl.found    = found;
    alu_ctl.fill_inv = !found && inv_found;
    alu_ctl.ref_rank = found ? hit_rank : oldest;
    alu_cur          = (state == ST_UPDATE) ? row_copy[idx] : rd_line;
  end

  salc_way_alu #(
    .WAY_W (WAY_W)
  ) u_alu (
    .ctl     (alu_ctl),
    .cur     (alu_cur),
    .tag     (tag_q),
    .oldest  (oldest),
    .way     (idx),
    .sel_way (sel_way),
    .stat    (alu_stat),
    .nxt     (alu_nxt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      inv_found <= 1'b0;
    end else if (accept) begin
      found     <= 1'b0;
      inv_found <= 1'b0;
    end else if (flags.eval) begin
      if (!found && alu_stat.match) begin
        found <= 1'b1;
      end
      if (!inv_found && alu_stat.invalid) begin
        inv_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flags.eval) begin
      row_copy[eval_way] <= rd_line;
      if (!found && alu_stat.match) begin
        hit_way  <= eval_way;
        hit_rank <= rd_line.rank;
      end
      if (!inv_found && alu_stat.invalid) begin
        inv_way <= eval_way;
      end
      // ties keep the lower way
      if (eval_way == '0 || alu_stat.greater) begin
        vic_way   <= eval_way;
        oldest    <= rd_line.rank;
        vic_dirty <= rd_line.dirty;
      end
    end
  end

  assign sel_way_x = {3'b000, sel_way};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (flags.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flags.finish) begin
      out_data.hit       <= found;
      out_data.writeback <= !found && !inv_found && vic_dirty;
      out_data.way_used  <= sel_way_x[2:0];
    end
  end

  `SALC_ASSERT_NOW(a_no_write_in_scan, state == ST_SCAN, !ram_we)
  `SALC_ASSERT_NOW(a_hit_never_writes_back, out_valid, !(out_data.hit && out_data.writeback))
  `SALC_ASSERT_NEXT(a_accept_starts_scan, in_valid && in_ready, state == ST_SCAN)
  `SALC_ASSERT_NEXT(a_finish_loads_result, flags.finish, out_valid)

endmodule

### tb/tb_set_assoc_lru_writeback_cache_tags_unit.sv
// Self-checking bench for set_assoc_lru_writeback_cache_tags_unit.
// Needs salc_pkg and the unit; predicts hit, writeback and way for every access
// with its own tag/LRU store and checks results in order.
module tb_set_assoc_lru_writeback_cache_tags_unit;
  import salc_pkg::*;

  localparam int NUM_SETS = 256;
  localparam int NUM_WAYS = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 2 * NUM_WAYS + 24;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 145;
  localparam int NUM_PHASES = 10;
  localparam int POOL_TAGS = 12;
  localparam logic CMD_READ = 1'b0;

  class cache_tag_scoreboard;
    bit [31:0] tag_mem[NUM_SETS*NUM_WAYS];
    bit        valid_mem[NUM_SETS*NUM_WAYS];
    bit        dirty_mem[NUM_SETS*NUM_WAYS];
    bit [2:0]  rank_mem[NUM_SETS*NUM_WAYS];
    bit [4:0]  offset_bits;
    bit [3:0]  set_bits;
    bit [3:0]  ways_cfg;
    out_item_t lookup_outcomes[$];
    int        errors;

    function new();
      offset_bits = OFFSET_BITS_RST;
      set_bits = SET_BITS_RST;
      ways_cfg = WAYS_IN_USE_RST;
      errors = 0;
      foreach (tag_mem[i]) begin
        tag_mem[i] = '0;
        valid_mem[i] = 1'b0;
        dirty_mem[i] = 1'b0;
        rank_mem[i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_OFFSET_BITS: offset_bits = val[4:0];
        CFG_SET_BITS:    set_bits = val[3:0];
        CFG_WAYS_IN_USE: ways_cfg = val[3:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return lookup_outcomes.size();
    endfunction

    // way w becomes most recent; valid ways younger than it age by one
    function void promote(int unsigned base, int unsigned nw, int unsigned w);
      bit [2:0] r;
      r = rank_mem[base+w];
      for (int unsigned k = 0; k < nw; k++)
        if (k != w && valid_mem[base+k] && rank_mem[base+k] < r && rank_mem[base+k] != RANK_MAX)
          rank_mem[base+k]++;
      rank_mem[base+w] = '0;
    endfunction

    function void note_access(in_item_t acc);
      int unsigned off, sb, nw, set_idx, base, w, victim;
      bit [63:0] wide;
      bit [31:0] tag;
      bit [2:0]  oldest;
      bit        found;
      out_item_t res;
      off = offset_bits;
      sb = set_bits;
      while (sb > 0 && (1 << sb) > NUM_SETS) sb--;
      nw = ways_cfg;
      if (nw < 1) nw = 1;
      if (nw > NUM_WAYS) nw = NUM_WAYS;
      set_idx = (acc.addr >> off) & ((1 << sb) - 1);
      wide = {32'd0, acc.addr};
      wide = wide >> (off + sb);
      tag = wide[31:0];
      base = set_idx * NUM_WAYS;
      found = 1'b0;
      res = '0;
      for (w = 0; w < nw; w++)
        if (valid_mem[base+w] && tag_mem[base+w] == tag) begin
          found = 1'b1;
          break;
        end
      if (found) begin
        res.hit = 1'b1;
        promote(base, nw, w);
        if (acc.cmd == CMD_WRITE) dirty_mem[base+w] = 1'b1;
      end else begin
        for (w = 0; w < nw; w++)
          if (!valid_mem[base+w]) break;
        if (w < nw) begin
          for (int unsigned k = 0; k < nw; k++)
            if (valid_mem[base+k] && rank_mem[base+k] != RANK_MAX) rank_mem[base+k]++;
          rank_mem[base+w] = '0;
        end else begin
          // oldest rank wins, lowest way on a tie
          victim = 0;
          oldest = rank_mem[base];
          for (int unsigned k = 1; k < nw; k++)
            if (rank_mem[base+k] > oldest) begin
              oldest = rank_mem[base+k];
              victim = k;
            end
          w = victim;
          res.writeback = dirty_mem[base+w];
          promote(base, nw, w);
        end
        tag_mem[base+w] = tag;
        valid_mem[base+w] = 1'b1;
        dirty_mem[base+w] = (acc.cmd == CMD_WRITE);
      end
      res.way_used = w[2:0];
      lookup_outcomes.push_back(res);
    endfunction

    function void check_outcome(out_item_t got);
      out_item_t want;
      if (lookup_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = lookup_outcomes.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, got.hit);
        errors++;
      end
      if (got.writeback !== want.writeback) begin
        $display("%0t: writeback mismatch, expected %0b, actual %0b", $time,
                 want.writeback, got.writeback);
        errors++;
      end
      if (got.way_used !== want.way_used) begin
        $display("%0t: way_used mismatch, expected %0d, actual %0d", $time,
                 want.way_used, got.way_used);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;

  cache_tag_scoreboard sb;
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        cur_off;
  int        cur_sb;
  int        cur_ways;
  bit        hold_request;
  int        cycle_count;
  logic [31:0] tag_pool[POOL_TAGS];
  logic [7:0]  set_pool[4];

  set_assoc_lru_writeback_cache_tags_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_outcome(out_data);

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_access(input logic cmd, input logic [31:0] addr);
    in_item_t item;
    item.cmd = cmd;
    item.addr = addr;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_access(item);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop valid, wait for every outstanding result, then let the update pass finish
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_geometry(input int off, input int sbits, input int ways);
    write_reg(CFG_OFFSET_BITS, off[CFG_DATA_W-1:0]);
    write_reg(CFG_SET_BITS, sbits[CFG_DATA_W-1:0]);
    write_reg(CFG_WAYS_IN_USE, ways[CFG_DATA_W-1:0]);
    cur_off = off;
    cur_sb = (sbits > 8) ? 8 : sbits;
    cur_ways = (ways < 1) ? 1 : (ways > NUM_WAYS) ? NUM_WAYS : ways;
  endtask

  function automatic logic [31:0] build_addr(input logic [31:0] tg, input logic [7:0] st);
    logic [63:0] low_mask;
    logic [63:0] set_part;
    logic [63:0] a;
    low_mask = (64'd1 << cur_off) - 64'd1;
    set_part = ({56'd0, st} & ((64'd1 << cur_sb) - 64'd1)) << cur_off;
    a = ({32'd0, tg} << (cur_off + cur_sb)) | set_part | ({32'd0, $urandom} & low_mask);
    return a[31:0];
  endfunction

  initial begin
    int geo[NUM_PHASES][3];
    int pick;
    int tag_span;
    logic [31:0] addr;

    geo = '{'{5, 4, 4}, '{0, 0, 1}, '{16, 8, 8}, '{3, 2, 2}, '{31, 15, 0},
            '{7, 3, 15}, '{24, 8, 8}, '{1, 1, 5}, '{12, 6, 3}, '{4, 8, 7}};
    sb = new();
    cycle_count = 0;
    hold_request = 1'b0;
    tx_idle_pct = 37;
    rx_idle_pct = 64;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: fills, hits, dirty evictions and address extremes with
    // 32-byte blocks and 16 sets
    set_geometry(5, 4, 4);
    send_access(CMD_READ,  32'h0000_0000);
    send_access(CMD_WRITE, 32'h0000_0000);
    send_access(CMD_WRITE, 32'hFFFF_FFFF);
    send_access(CMD_READ,  32'hFFFF_FFFF);
    send_access(CMD_READ,  32'h0000_0200);
    send_access(CMD_WRITE, 32'h0000_0400);
    send_access(CMD_READ,  32'h0000_0600);
    send_access(CMD_READ,  32'h0000_0800);
    send_access(CMD_READ,  32'h0000_0200);
    send_access(CMD_WRITE, 32'h0000_0A00);
    send_access(CMD_READ,  32'h0000_0000);
    send_access(CMD_WRITE, 32'h0000_001F);
    send_access(CMD_READ,  32'hFFFF_FFE0);
    send_access(CMD_WRITE, 32'h8000_0000);
    send_access(CMD_READ,  32'h0000_01E0);
    send_access(CMD_READ,  32'h7FFF_FFFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      set_geometry(geo[p][0], geo[p][1], geo[p][2]);
      if (p < 4) begin
        tx_idle_pct = 37;
        rx_idle_pct = 64;
      end else if (p < 7) begin
        tx_idle_pct = 64;
        rx_idle_pct = 37;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      foreach (set_pool[i]) set_pool[i] = 8'($urandom_range(0, 255));
      tag_span = (cur_ways + 2 < POOL_TAGS) ? cur_ways + 2 : POOL_TAGS - 1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (p == 0 && i == 20) hold_request = 1'b1;
        pick = $urandom_range(0, 99);
        // mostly a small working set per set so hits and evictions both occur
        if (pick < 12)
          addr = $urandom;
        else
          addr = build_addr(tag_pool[$urandom_range(0, tag_span)],
                            set_pool[$urandom_range(0, 3)]);
        send_access(1'($urandom_range(0, 1)), addr);
      end
    end

    drain();
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/salc_way_alu.sv
rtl/salc_ctrl.sv
rtl/set_assoc_lru_writeback_cache_tags_unit.sv
tb/tb_set_assoc_lru_writeback_cache_tags_unit.sv
